// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define TMC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define TMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and constants of the three-window mean correlation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int EPS_W       = 41;
   localparam logic [EPS_W-1:0] EPS_RESET = 41'd4295;
   localparam int CORR_W      = 32;
   localparam int QDEPTH      = 2;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);
   localparam int VV_SHIFT    = 32;
   localparam int DIV_SHIFT   = 31;
   localparam int Y_W         = 63;
   localparam int Q_W         = 32;
   localparam int STEP_W      = 6;
   localparam int SUM_ACC_W   = 35;
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
   localparam int RECIP3_SHIFT = 33;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;
   localparam logic REG_EPSILON = 1'b0;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } q_status_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_PROD,
      BK_DIFF,
      BK_N2,
      BK_N4,
      BK_FLOOR,
      BK_PAIR,
      BK_VV,
      BK_CC,
      BK_DEN,
      BK_DIV,
      BK_SQRT,
      BK_ADD,
      BK_DIV3,
      BK_OUT
   } bk_state_type;

endpackage

`default_nettype wire

// ===== design/three_window_mean_correlation_core.sv =====
// ----------------------------------------------------------------------------
// three_window_mean_correlation_core
// Mean of the three pairwise normalized cross correlations of three windows.
// ----------------------------------------------------------------------------
// Usage:
//   A sample triple word (req_sample_a/b/c, req_last) is taken on a clock
//   edge with start high and busy low, one word per cycle. A window closes
//   on req_last or when MAX_WINDOW samples have been taken.
//   Each closed window gives one result on rsp_correlation (signed Q2.30),
//   marked by rsp_valid for a single cycle; the receiver cannot stall it.
//   The front accumulates each taken word; closed windows wait in a
//   two-entry snapshot queue for the back sequencer.
//   The back sequencer handles one window at a time with a shift-add
//   multiplier (54 bits wide at default parameters): two serial
//   multiplies per pair plus one for the floor, a 63-step division and a
//   32-step square root; a pair with zero covariance skips its multiplies,
//   division and root.
//   busy rises only while the queue could not take another closed window.
//   Register epsilon (8-byte register at address 0) sets the variance floor.
//   Reset clears the sums, the queue and the sequencer; epsilon returns to
//   its default.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_window_mean_correlation_core import tmc_pkg::*; #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [SAMPLE_W-1:0]   req_sample_a,
   input  wire logic [SAMPLE_W-1:0]   req_sample_b,
   input  wire logic [SAMPLE_W-1:0]   req_sample_c,
   input  wire logic                  req_last,
   output logic                       rsp_valid,
   output logic signed [CORR_W-1:0]   rsp_correlation,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
   localparam int SNAP_W = CNT_W + 3 * SUM_W + 6 * SQ_W;

   logic [EPS_W-1:0]  eps_ff, eps_in;
   logic              csr_write;
   logic              push, pop;
   logic [SNAP_W-1:0] push_data, pop_data;
   q_status_type      q_status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign eps_in    = (csr_write && paddr[3] == REG_EPSILON) ? pwdata[EPS_W-1:0] : eps_ff;
   assign prdata    = (paddr[3] == REG_EPSILON) ? CSR_DATA_W'(eps_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else begin
         eps_ff <= eps_in;
      end
   end

   tmc_front #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .sample_a  (req_sample_a),
      .sample_b  (req_sample_b),
      .sample_c  (req_sample_c),
      .last      (req_last),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   tmc_queue #(.WIDTH(SNAP_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   tmc_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .epsilon         (eps_ff),
      .q_status        (q_status),
      .snap            (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_correlation (rsp_correlation)
   );

endmodule

`default_nettype wire

// ===== design/tmc_front.sv =====
// ----------------------------------------------------------------------------
// tmc_front
// Takes sample triples, forms squares and cross products, accumulates the
// window sums and pushes a snapshot of them when the window closes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmc_front import tmc_pkg::*; #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16,
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W  = SAMPLE_BITS + CNT_W,
   localparam int PROD_W = 2 * SAMPLE_BITS,
   localparam int SQ_W   = PROD_W + CNT_W,
   localparam int SNAP_W = CNT_W + 3 * SUM_W + 6 * SQ_W
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [SAMPLE_W-1:0] sample_a,
   input  wire logic [SAMPLE_W-1:0] sample_b,
   input  wire logic [SAMPLE_W-1:0] sample_c,
   input  wire logic                last,
   input  wire q_status_type        q_status,
   output logic                     push,
   output logic [SNAP_W-1:0]        push_data
);

   logic                   accept;
   logic [CNT_W-1:0]       n_new;
   logic                   close;
   logic [SAMPLE_BITS-1:0] smp [3];

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_close_ff, s1_close_in;
   logic [CNT_W-1:0]       s1_n_ff, s1_n_in;
   logic [SAMPLE_BITS-1:0] smp_ff [3];
   logic [SAMPLE_BITS-1:0] smp_in [3];
   logic [PROD_W-1:0]      prod_ff [6];
   logic [PROD_W-1:0]      prod_in [6];
   logic [SUM_W-1:0]       sum_ff [3];
   logic [SUM_W-1:0]       sum_in [3];
   logic [SQ_W-1:0]        acc_ff [6];
   logic [SQ_W-1:0]        acc_in [6];
   logic [SUM_W-1:0]       sum_nx [3];
   logic [SQ_W-1:0]        acc_nx [6];

   // hold off while a closing word could find the queue full
   assign busy   = ({1'b0, q_status.count} + (QCNT_W + 1)'(s1_valid_ff && s1_close_ff))
                   >= (QCNT_W + 1)'(QDEPTH);
   assign accept = start && !busy;
   assign n_new  = cnt_ff + CNT_W'(1);
   assign close  = last || (n_new == CNT_W'(MAX_WINDOW));

   assign smp[0] = sample_a[SAMPLE_BITS-1:0];
   assign smp[1] = sample_b[SAMPLE_BITS-1:0];
   assign smp[2] = sample_c[SAMPLE_BITS-1:0];

   always_comb begin
      cnt_in      = cnt_ff;
      s1_valid_in = accept;
      s1_close_in = accept && close;
      s1_n_in     = n_new;
      for (int i = 0; i < 3; i++) begin
         smp_in[i] = smp[i];
      end
      prod_in[0] = PROD_W'(smp[0]) * PROD_W'(smp[0]);
      prod_in[1] = PROD_W'(smp[1]) * PROD_W'(smp[1]);
      prod_in[2] = PROD_W'(smp[2]) * PROD_W'(smp[2]);
      prod_in[3] = PROD_W'(smp[0]) * PROD_W'(smp[1]);
      prod_in[4] = PROD_W'(smp[0]) * PROD_W'(smp[2]);
      prod_in[5] = PROD_W'(smp[1]) * PROD_W'(smp[2]);
      if (accept) begin
         cnt_in = close ? '0 : n_new;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_nx[i] = sum_ff[i] + SUM_W'(smp_ff[i]);
         sum_in[i] = sum_ff[i];
      end
      for (int k = 0; k < 6; k++) begin
         acc_nx[k] = acc_ff[k] + SQ_W'(prod_ff[k]);
         acc_in[k] = acc_ff[k];
      end
      if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            sum_in[i] = s1_close_ff ? '0 : sum_nx[i];
         end
         for (int k = 0; k < 6; k++) begin
            acc_in[k] = s1_close_ff ? '0 : acc_nx[k];
         end
      end
   end

   assign push      = s1_valid_ff && s1_close_ff;
   assign push_data = {s1_n_ff, sum_nx[0], sum_nx[1], sum_nx[2],
                       acc_nx[0], acc_nx[1], acc_nx[2], acc_nx[3], acc_nx[4], acc_nx[5]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_close_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
         for (int k = 0; k < 6; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         s1_close_ff <= s1_close_in;
         sum_ff      <= sum_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_n_ff <= s1_n_in;
      smp_ff  <= smp_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== design/tmc_queue.sv =====
// ----------------------------------------------------------------------------
// tmc_queue
// Short flop queue of window snapshots between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmc_queue import tmc_pkg::*; #(
   parameter int WIDTH = 8,
   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output q_status_type          status
);

   logic [WIDTH-1:0]  entry_ff [QDEPTH];
   logic [WIDTH-1:0]  entry_in [QDEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = ptr_next(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== design/tmc_seqmul.sv =====
// ----------------------------------------------------------------------------
// tmc_seqmul
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmc_seqmul #(
   parameter int A_W = 8,
   parameter int B_W = 8,
   localparam int P_W = A_W + B_W,
   localparam int C_W = $clog2(B_W)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [A_W-1:0] a,
   input  wire logic [B_W-1:0] b,
   output logic                done,
   output logic [P_W-1:0]      prod
);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [C_W-1:0]   cnt_ff, cnt_in;
   logic [P_W-1:0]   mcand_ff, mcand_in;
   logic [B_W-1:0]   mplier_ff, mplier_in;
   logic [P_W-1:0]   acc_ff, acc_in;

   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         run_in    = 1'b1;
         cnt_in    = C_W'(B_W - 1);
         mcand_in  = P_W'(a);
         mplier_in = b;
         acc_in    = '0;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - C_W'(1);
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

endmodule

`default_nettype wire

// ===== design/tmc_back.sv =====
// ----------------------------------------------------------------------------
// tmc_back
// Sequencer that turns one window snapshot into the mean pairwise
// correlation: covariances, variance floor, long division and square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmc_back import tmc_pkg::*; #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16,
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W  = SAMPLE_BITS + CNT_W,
   localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W,
   localparam int SNAP_W = CNT_W + 3 * SUM_W + 6 * SQ_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [EPS_W-1:0]  epsilon,
   input  wire q_status_type      q_status,
   input  wire logic [SNAP_W-1:0] snap,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic signed [CORR_W-1:0] rsp_correlation
);

   localparam int VW    = CNT_W + SQ_W;
   localparam int N2_W  = 2 * CNT_W;
   localparam int N4_W  = 4 * CNT_W;
   localparam int FL_W  = EPS_W + N4_W;
   localparam int MA    = (VW > EPS_W) ? VW : EPS_W;
   localparam int MB    = (VW > N4_W) ? VW : N4_W;
   localparam int PW    = MA + MB;
   localparam int VV_W  = 2 * VW;
   localparam int DEN_W = VV_W + VV_SHIFT;
   localparam int REM_W = DEN_W + 1;

   bk_state_type state_ff, state_in;

   logic [CNT_W-1:0] n_ff, n_in;
   logic [SUM_W-1:0] s_ff [3];
   logic [SUM_W-1:0] s_in [3];
   logic [SQ_W-1:0]  q_ff [6];
   logic [SQ_W-1:0]  q_in [6];
   logic [2:0]       k_ff, k_in;
   logic [1:0]       pr_ff, pr_in;
   logic [VW-1:0]    pa_ff, pa_in;
   logic [VW-1:0]    pb_ff, pb_in;
   logic [VW-1:0]    val_ff [6];
   logic [VW-1:0]    val_in [6];
   logic             neg_ff [6];
   logic             neg_in [6];
   logic [N2_W-1:0]  n2_ff, n2_in;
   logic [FL_W-1:0]  fl_ff, fl_in;
   logic [VV_W-1:0]  vv_ff, vv_in;
   logic [VV_W-1:0]  cc_ff, cc_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [Y_W-1:0]   y_ff, y_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [Q_W-1:0]   qr_ff, qr_in;
   logic signed [SUM_ACC_W-1:0] acc_ff, acc_in;
   logic [63:0]      x3_ff, x3_in;
   logic             sgn_ff, sgn_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [CORR_W-1:0] rsp_corr_ff, rsp_corr_in;

   logic             mul_start;
   logic [MA-1:0]    mul_a;
   logic [MB-1:0]    mul_b;
   logic             mul_done;
   logic [PW-1:0]    mul_prod;

   logic [1:0]       si, sj;
   logic [2:0]       vi, vj, ci;
   logic [CNT_W-1:0] n_snap;
   logic [SUM_W-1:0] s_snap [3];
   logic [SQ_W-1:0]  q_snap [6];
   logic [DEN_W-1:0] vvs, fl_ext, den_c;
   logic [REM_W-1:0] sh;
   logic             ge;
   logic [Q_W-1:0]   t;
   logic [63:0]      tt;
   logic [Q_W:0]     p33;
   logic [SUM_ACC_W-1:0] pext;
   logic [SUM_ACC_W-1:0] acc_abs;
   logic [31:0]      x;
   logic [31:0]      m;

   tmc_seqmul #(.A_W(MA), .B_W(MB)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   always_comb begin
      n_snap = snap[SNAP_W-1 -: CNT_W];
      for (int i = 0; i < 3; i++) begin
         s_snap[i] = snap[6 * SQ_W + (2 - i) * SUM_W +: SUM_W];
      end
      for (int k = 0; k < 6; k++) begin
         q_snap[k] = snap[(5 - k) * SQ_W +: SQ_W];
      end
   end

   // which sums go with each product term
   always_comb begin
      unique case (k_ff)
         3'd0:    begin si = 2'd0; sj = 2'd0; end
         3'd1:    begin si = 2'd1; sj = 2'd1; end
         3'd2:    begin si = 2'd2; sj = 2'd2; end
         3'd3:    begin si = 2'd0; sj = 2'd1; end
         3'd4:    begin si = 2'd0; sj = 2'd2; end
         3'd5:    begin si = 2'd1; sj = 2'd2; end
         default: begin si = 2'd0; sj = 2'd0; end
      endcase
   end

   // pair ab, ac, bc: covariance entry and its two variances
   assign ci = 3'd3 + 3'(pr_ff);
   assign vi = (pr_ff == 2'd2) ? 3'd1 : 3'd0;
   assign vj = (pr_ff == 2'd0) ? 3'd1 : 3'd2;

   assign vvs    = {vv_ff, {VV_SHIFT{1'b0}}};
   assign fl_ext = DEN_W'(fl_ff);
   assign den_c  = (vvs >= fl_ext) ? vvs : fl_ext;
   assign sh     = {rem_ff[DEN_W-1:0], 1'b0};
   assign ge     = sh >= {1'b0, den_ff};
   assign t      = qr_ff | (Q_W'(1) << step_ff);
   assign tt     = 64'(t) * 64'(t);
   assign p33    = ({1'b0, qr_ff} + (Q_W + 1)'(1)) >> 1;
   assign pext   = {{(SUM_ACC_W - Q_W){1'b0}}, p33[Q_W-1:0]};
   assign acc_abs = acc_ff[SUM_ACC_W-1] ? SUM_ACC_W'(-acc_ff) : SUM_ACC_W'(acc_ff);
   assign x      = acc_abs[31:0] + 32'd1;
   assign m      = 32'(x3_ff >> RECIP3_SHIFT);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      pr_in        = pr_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      val_in       = val_ff;
      neg_in       = neg_ff;
      n2_in        = n2_ff;
      fl_in        = fl_ff;
      vv_in        = vv_ff;
      cc_in        = cc_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      y_in         = y_ff;
      step_in      = step_ff;
      qr_in        = qr_ff;
      acc_in       = acc_ff;
      x3_in        = x3_ff;
      sgn_in       = sgn_ff;
      rsp_valid_in = 1'b0;
      rsp_corr_in  = rsp_corr_ff;
      pop          = 1'b0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               n_in     = n_snap;
               s_in     = s_snap;
               q_in     = q_snap;
               k_in     = '0;
               acc_in   = '0;
               state_in = BK_PROD;
            end
         end
         BK_PROD: begin
            pa_in    = VW'(n_ff) * VW'(q_ff[k_ff]);
            pb_in    = VW'(s_ff[si]) * VW'(s_ff[sj]);
            state_in = BK_DIFF;
         end
         BK_DIFF: begin
            if (pa_ff >= pb_ff) begin
               val_in[k_ff] = pa_ff - pb_ff;
               neg_in[k_ff] = 1'b0;
            end else begin
               val_in[k_ff] = pb_ff - pa_ff;
               neg_in[k_ff] = 1'b1;
            end
            if (k_ff == 3'd5) begin
               state_in = BK_N2;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = BK_PROD;
            end
         end
         BK_N2: begin
            n2_in    = N2_W'(n_ff) * N2_W'(n_ff);
            state_in = BK_N4;
         end
         BK_N4: begin
            mul_start = 1'b1;
            mul_a     = MA'(epsilon);
            mul_b     = MB'(n2_ff) * MB'(n2_ff);
            state_in  = BK_FLOOR;
         end
         BK_FLOOR: begin
            if (mul_done) begin
               fl_in    = mul_prod[FL_W-1:0];
               pr_in    = '0;
               state_in = BK_PAIR;
            end
         end
         BK_PAIR: begin
            if (val_ff[ci] == '0) begin
               // zero covariance adds nothing
               qr_in    = '0;
               state_in = BK_ADD;
            end else begin
               mul_start = 1'b1;
               mul_a     = MA'(val_ff[vi]);
               mul_b     = MB'(val_ff[vj]);
               state_in  = BK_VV;
            end
         end
         BK_VV: begin
            if (mul_done) begin
               vv_in     = mul_prod[VV_W-1:0];
               mul_start = 1'b1;
               mul_a     = MA'(val_ff[ci]);
               mul_b     = MB'(val_ff[ci]);
               state_in  = BK_CC;
            end
         end
         BK_CC: begin
            if (mul_done) begin
               cc_in    = mul_prod[VV_W-1:0];
               state_in = BK_DEN;
            end
         end
         BK_DEN: begin
            den_in  = den_c;
            rem_in  = REM_W'(cc_ff) << DIV_SHIFT;
            y_in    = '0;
            qr_in   = '0;
            step_in = STEP_W'(Y_W - 1);
            state_in = (den_c == '0) ? BK_ADD : BK_DIV;
         end
         BK_DIV: begin
            // one quotient bit of c^2 * 2^94 / den per cycle
            rem_in = ge ? sh - {1'b0, den_ff} : sh;
            y_in   = {y_ff[Y_W-2:0], ge};
            if (step_ff == '0) begin
               step_in  = STEP_W'(Q_W - 1);
               state_in = BK_SQRT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         BK_SQRT: begin
            if (tt <= {1'b0, y_ff}) begin
               qr_in = t;
            end
            if (step_ff == '0) begin
               state_in = BK_ADD;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         BK_ADD: begin
            acc_in = neg_ff[ci] ? acc_ff - $signed(pext) : acc_ff + $signed(pext);
            if (pr_ff == 2'd2) begin
               state_in = BK_DIV3;
            end else begin
               pr_in    = pr_ff + 2'd1;
               state_in = BK_PAIR;
            end
         end
         BK_DIV3: begin
            // divide by three through the reciprocal
            x3_in    = 64'(x) * 64'(RECIP3);
            sgn_in   = acc_ff[SUM_ACC_W-1];
            state_in = BK_OUT;
         end
         BK_OUT: begin
            rsp_corr_in  = sgn_ff ? $signed(-m) : $signed(m);
            rsp_valid_in = 1'b1;
            state_in     = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_correlation = rsp_corr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      s_ff        <= s_in;
      q_ff        <= q_in;
      k_ff        <= k_in;
      pr_ff       <= pr_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      val_ff      <= val_in;
      neg_ff      <= neg_in;
      n2_ff       <= n2_in;
      fl_ff       <= fl_in;
      vv_ff       <= vv_in;
      cc_ff       <= cc_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      y_ff        <= y_in;
      step_ff     <= step_in;
      qr_ff       <= qr_in;
      acc_ff      <= acc_in;
      x3_ff       <= x3_in;
      sgn_ff      <= sgn_in;
      rsp_corr_ff <= rsp_corr_in;
   end

endmodule

`default_nettype wire

// ===== design/tmc_checker.sv =====
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks of the correlation core, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tmc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_correlation,
   input wire logic        pready
);

   // a window result runs the whole back sequence, so strobes never touch
   `TMC_ASSERT(a_single_strobe, clock, reset, rsp_valid |=> !rsp_valid,
      "result strobe held two cycles")

   `TMC_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> (!rsp_valid && !busy),
      "activity right after reset")

   `TMC_ASSERT(a_corr_range, clock, reset,
      rsp_valid |-> ($signed(rsp_correlation) >= -32'sd1073741824
                     && $signed(rsp_correlation) <= 32'sd1073741824),
      "correlation outside unit range")

   `TMC_ASSERT_ALWAYS(a_pready_high, clock, pready, "pready dropped")

endmodule

bind three_window_mean_correlation_core tmc_checker u_tmc_checker (.*);

`default_nettype wire

// ===== bench/three_window_mean_correlation_core_tb.sv =====
// ----------------------------------------------------------------------------
// three_window_mean_correlation_core_tb
// Drives sample triple words and epsilon writes into the core, predicts the
// mean pairwise correlation of each closed window and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class corr_scoreboard;
   bit [40:0]   eps;
   bit [63:0]   cnt, sa, sb, sc;
   bit [63:0]   sq [3];
   bit [63:0]   xs [3];
   logic signed [31:0] expected_corr [$];
   int          errors;

   function new();
      eps = 41'(tmc_pkg::EPS_RESET);
      errors = 0;
      clear_window();
   endfunction

   function void clear_window();
      cnt = 0; sa = 0; sb = 0; sc = 0;
      for (int i = 0; i < 3; i++) begin
         sq[i] = 0;
         xs[i] = 0;
      end
   endfunction

   function automatic bit [63:0] abs_diff(bit [63:0] x, bit [63:0] y, output bit neg);
      neg = x < y;
      return neg ? y - x : x - y;
   endfunction

   function automatic longint pair_corr(bit [63:0] cmag, bit cneg, bit [63:0] vi,
                                        bit [63:0] vj, bit [63:0] n);
      bit [255:0] vv, fl, den, rhs, lhs;
      bit [63:0]  q, t, p;
      if (cmag == 0) return 0;
      vv = (256'(vi) * 256'(vj)) << 32;
      fl = 256'(eps) * 256'(n * n * n * n);
      den = (vv >= fl) ? vv : fl;
      if (den == 0) return 0;
      rhs = (256'(cmag) * 256'(cmag)) << 94;
      q = 0;
      // largest q with q^2 * den <= 2^94 * c^2
      for (int b = 31; b >= 0; b--) begin
         t = q | (64'd1 << b);
         lhs = 256'(t * t) * den;
         if (lhs <= rhs) q = t;
      end
      p = (q + 1) >> 1;
      return cneg ? -longint'(p) : longint'(p);
   endfunction

   function void take_word(bit [15:0] a, bit [15:0] b, bit [15:0] c, bit last);
      bit [63:0] n, vaa, vbb, vcc, cab, cac, cbc;
      bit        nab, nac, nbc, dummy;
      longint    s, mag;
      sa += a; sb += b; sc += c;
      sq[0] += 64'(a) * a; sq[1] += 64'(b) * b; sq[2] += 64'(c) * c;
      xs[0] += 64'(a) * b; xs[1] += 64'(a) * c; xs[2] += 64'(b) * c;
      cnt++;
      if (!last && cnt < 1024) return;
      n = cnt;
      vaa = abs_diff(n * sq[0], sa * sa, dummy);
      vbb = abs_diff(n * sq[1], sb * sb, dummy);
      vcc = abs_diff(n * sq[2], sc * sc, dummy);
      cab = abs_diff(n * xs[0], sa * sb, nab);
      cac = abs_diff(n * xs[1], sa * sc, nac);
      cbc = abs_diff(n * xs[2], sb * sc, nbc);
      s = pair_corr(cab, nab, vaa, vbb, n) + pair_corr(cac, nac, vaa, vcc, n)
        + pair_corr(cbc, nbc, vbb, vcc, n);
      mag = (s < 0) ? -s : s;
      mag = (mag + 1) / 3;
      s = (s < 0) ? -mag : mag;
      expected_corr = {expected_corr, 32'(s)};
      clear_window();
   endfunction

   function void check_corr(logic signed [31:0] actual);
      logic signed [31:0] want;
      if (expected_corr.size() == 0) begin
         $display("%0t: unexpected result, actual %0d", $time, actual);
         errors++;
         return;
      end
      want = expected_corr.pop_front();
      if (actual !== want) begin
         $display("%0t: correlation mismatch, expected %0d, actual %0d",
                  $time, want, actual);
         errors++;
      end
   endfunction
endclass

module three_window_mean_correlation_core_tb;
   import tmc_pkg::*;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam bit [40:0] EPS_MAX = '1;
   localparam logic [CSR_ADDR_W-1:0] EPS_ADDR = CSR_ADDR_W'(8 * REG_EPSILON);

   logic clock, reset, start, busy;
   logic [15:0] req_sample_a, req_sample_b, req_sample_c;
   logic req_last, rsp_valid;
   logic signed [31:0] rsp_correlation;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   corr_scoreboard scb;
   longint cycles;
   bit no_gaps;

   three_window_mean_correlation_core dut (
      .clock, .reset, .start, .busy, .req_sample_a, .req_sample_b, .req_sample_c,
      .req_last, .rsp_valid, .rsp_correlation, .psel, .penable, .pwrite, .paddr,
      .pwdata, .prdata, .pready
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) scb.check_corr(rsp_correlation);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return;
      start <= 1'b0;
      if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 80)) @(posedge clock);
   endtask

   task automatic send_word(bit [15:0] a, bit [15:0] b, bit [15:0] c, bit last);
      idle_gap();
      start <= 1'b1;
      req_sample_a <= a;
      req_sample_b <= b;
      req_sample_c <= c;
      req_last <= last;
      do @(posedge clock); while (busy);
      scb.take_word(a, b, c, last);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (scb.expected_corr.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == EPS_ADDR) scb.eps = value[40:0];
      @(posedge clock);
   endtask

   // one window of random length and flavor
   task automatic send_window(int len);
      int kind;
      bit [15:0] a, b, c, msk;
      kind = $urandom_range(0, 5);
      msk = ($urandom_range(0, 3) == 0) ? 16'h00ff : 16'hffff;
      for (int i = 0; i < len; i++) begin
         a = 16'($urandom) & msk;
         b = 16'($urandom) & msk;
         c = 16'($urandom) & msk;
         case (kind)
            1: begin
               b = a + 16'($urandom_range(0, 300));
               c = a - 16'($urandom_range(0, 300));
            end
            2: begin
               b = ~a;
               c = a ^ 16'($urandom_range(0, 15));
            end
            3: c = 16'h1234;
            4: begin
               b = a;
               c = a;
            end
            default: ;
         endcase
         send_word(a, b, c, i == len - 1);
      end
   endtask

   task automatic random_phase(int items);
      int done, len;
      done = 0;
      while (done < items) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                           : $urandom_range(1, 16);
         send_window(len);
         done += len;
      end
      no_gaps = 0;
   endtask

   initial begin
      int wait_cycles;
      scb = new();
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_sample_a = '0;
      req_sample_b = '0;
      req_sample_c = '0;
      req_last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      no_gaps = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-sample window, then zero variance everywhere
      send_word(16'hffff, 16'hffff, 16'hffff, 1'b1);
      send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
      // full-scale swings, b follows a, c opposes it
      send_word(16'h0000, 16'h0000, 16'hffff, 1'b0);
      send_word(16'hffff, 16'hffff, 16'h0000, 1'b0);
      send_word(16'h0000, 16'h0001, 16'hffff, 1'b0);
      send_word(16'hffff, 16'hfffe, 16'h0000, 1'b1);
      // one channel constant
      send_word(16'h0010, 16'h0777, 16'h5555, 1'b0);
      send_word(16'h0020, 16'h0555, 16'h5555, 1'b0);
      send_word(16'h0030, 16'h0999, 16'h5555, 1'b1);
      drain();

      // zero floor with a flat channel, then the largest floor
      csr_write(EPS_ADDR, 64'd0);
      send_word(16'h0001, 16'h0007, 16'h0003, 1'b0);
      send_word(16'h0002, 16'h0007, 16'h0001, 1'b1);
      drain();
      csr_write(EPS_ADDR, {23'h7fffff, EPS_MAX});
      send_word(16'h0001, 16'h0002, 16'h0003, 1'b0);
      send_word(16'h0002, 16'h0001, 16'h0004, 1'b0);
      send_word(16'h0003, 16'h0003, 16'h0003, 1'b1);
      drain();
      // write to an unknown register must leave epsilon alone
      csr_write(CSR_ADDR_W'(8), 64'd12345);
      csr_write(EPS_ADDR, 64'(EPS_RESET));

      random_phase(220);
      drain();
      csr_write(EPS_ADDR, 64'd0);
      random_phase(190);
      drain();
      csr_write(EPS_ADDR, 64'($urandom) << $urandom_range(0, 9));
      random_phase(120);
      // sender holds off until the back end has caught up
      drain();
      random_phase(100);
      drain();
      csr_write(EPS_ADDR, 64'(EPS_MAX));
      random_phase(190);

      start <= 1'b0;
      wait_cycles = 0;
      while (scb.expected_corr.size() > 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (800) @(posedge clock);
      if (scb.errors == 0 && scb.expected_corr.size() == 0) begin
         $display("Regression PASS");
      end else begin
         if (scb.expected_corr.size() > 0)
            $display("%0t: %0d results never arrived", $time, scb.expected_corr.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/tmc_pkg.sv
design/tmc_front.sv
design/tmc_queue.sv
design/tmc_seqmul.sv
design/tmc_back.sv
design/three_window_mean_correlation_core.sv
design/tmc_checker.sv
bench/three_window_mean_correlation_core_tb.sv
